// File: rtl/core/tea_pkg.sv
// Shared types and constants for the TEA block cipher core.
// No dependencies; imported by every module under rtl/core.
package tea_pkg;

  // Data and configuration widths
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Default number of full cipher rounds
  localparam int ROUND_COUNT_DEF = 32;

  // Golden-ratio round constant
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0   = 3'd0,
    REG_KEY_WORD_1   = 3'd1,
    REG_KEY_WORD_2   = 3'd2,
    REG_KEY_WORD_3   = 3'd3,
    REG_DECRYPT_MODE = 3'd4
  } tea_reg_t;

  // Key and direction as seen by every pipeline stage
  typedef struct packed {
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
    logic              decrypt_mode;
  } tea_cfg_t;

  // Running sum after n steps, modulo 2^32 (elaboration-time use)
  function automatic logic [WORD_W-1:0] delta_times(input int n);
    logic [2*WORD_W-1:0] prod;
    prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// File: rtl/core/tea_cfg_regs.sv
// Configuration register file for the TEA core: four key words and direction.
// Depends on tea_pkg.
module tea_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata,
  output tea_pkg::tea_cfg_t             cfg
);
  import tea_pkg::*;

  tea_cfg_t cfg_r;
  tea_cfg_t cfg_nxt;

  // Write decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (tea_reg_t'(cfg_index))
        REG_KEY_WORD_0:   cfg_nxt.key_word_0   = cfg_wdata;
        REG_KEY_WORD_1:   cfg_nxt.key_word_1   = cfg_wdata;
        REG_KEY_WORD_2:   cfg_nxt.key_word_2   = cfg_wdata;
        REG_KEY_WORD_3:   cfg_nxt.key_word_3   = cfg_wdata;
        REG_DECRYPT_MODE: cfg_nxt.decrypt_mode = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/tea_half_stage.sv
// One pipeline stage of the TEA core: updates one half of the block.
// Depends on tea_pkg; instantiated 2*ROUND_COUNT times by the top level.
module tea_half_stage #(
  parameter int STAGE_IDX   = 0,
  parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tea_pkg::tea_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tea_pkg::WORD_W-1:0] in_v0,
  input  logic [tea_pkg::WORD_W-1:0] in_v1,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tea_pkg::WORD_W-1:0] out_v0,
  output logic [tea_pkg::WORD_W-1:0] out_v1
);
  import tea_pkg::*;

  // Round this stage belongs to, and which half of the round it is
  localparam int  RoundIdx  = STAGE_IDX / 2;
  localparam bit  FirstHalf = (STAGE_IDX % 2) == 0;
  localparam logic [WORD_W-1:0] EncSum = delta_times(RoundIdx + 1);
  localparam logic [WORD_W-1:0] DecSum = delta_times(ROUND_COUNT - RoundIdx);

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] v0_r;
  logic [WORD_W-1:0] v1_r;
  logic [WORD_W-1:0] v0_nxt;
  logic [WORD_W-1:0] v1_nxt;

  logic              upd_v0;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] key_a;
  logic [WORD_W-1:0] key_b;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_new;

  // Encrypt does v0 then v1; decrypt does v1 then v0
  assign upd_v0 = FirstHalf != cfg.decrypt_mode;
  assign src    = upd_v0 ? in_v1 : in_v0;
  assign dst    = upd_v0 ? in_v0 : in_v1;
  assign key_a  = upd_v0 ? cfg.key_word_0 : cfg.key_word_2;
  assign key_b  = upd_v0 ? cfg.key_word_1 : cfg.key_word_3;
  assign sum    = cfg.decrypt_mode ? DecSum : EncSum;

  // Mixing function and half update
  assign mix     = ((src << 4) + key_a) ^ (src + sum) ^ ((src >> 5) + key_b);
  assign dst_new = cfg.decrypt_mode ? (dst - mix) : (dst + mix);
  assign v0_nxt  = upd_v0 ? dst_new : in_v0;
  assign v1_nxt  = upd_v0 ? in_v1 : dst_new;

  // Stage takes a transfer when empty or when its contents move on
  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_v0    = v0_r;
  assign out_v1    = v1_r;

endmodule

// File: rtl/core/tea_block_cipher.sv
// TEA block cipher core, top level: config registers and the stage chain.
// Depends on tea_pkg, tea_cfg_regs and tea_half_stage.
//
// Encrypts or decrypts one 64-bit block (two 32-bit halves) per clock in
// ECB fashion. The datapath is a chain of 2*ROUND_COUNT pipeline stages, one
// half-round each. A block's result is held in the last stage register
// until it transfers out. A new block can be taken every cycle while the
// output side keeps up. Each stage holds its own valid bit and accepts a
// transfer whenever it is empty or draining, so bubbles collapse under
// back-pressure and nothing is dropped or duplicated.
// Key words and decrypt_mode are read live by every stage: write them only
// while the pipeline is empty.
module tea_block_cipher #(
  parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata,
  // input block channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tea_pkg::WORD_W-1:0]    in_half_first,
  input  logic [tea_pkg::WORD_W-1:0]    in_half_second,
  // result block channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tea_pkg::WORD_W-1:0]    out_result_first,
  output logic [tea_pkg::WORD_W-1:0]    out_result_second
);
  import tea_pkg::*;

  localparam int StageCount = 2 * ROUND_COUNT;

  tea_cfg_t cfg;

  // Handshake and data links between stages; link 0 is the input port
  logic              link_valid [StageCount+1];
  logic              link_ready [StageCount+1];
  logic [WORD_W-1:0] link_v0    [StageCount+1];
  logic [WORD_W-1:0] link_v1    [StageCount+1];

  tea_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];
  assign link_v0[0]    = in_half_first;
  assign link_v1[0]    = in_half_second;

  // Half-round stage chain
  for (genvar s = 0; s < StageCount; s++) begin : g_stage
    tea_half_stage #(
      .STAGE_IDX   (s),
      .ROUND_COUNT (ROUND_COUNT)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .in_valid  (link_valid[s]),
      .in_ready  (link_ready[s]),
      .in_v0     (link_v0[s]),
      .in_v1     (link_v1[s]),
      .out_valid (link_valid[s+1]),
      .out_ready (link_ready[s+1]),
      .out_v0    (link_v0[s+1]),
      .out_v1    (link_v1[s+1])
    );
  end

  // Last stage register is the output register
  assign out_valid             = link_valid[StageCount];
  assign link_ready[StageCount] = out_ready;
  assign out_result_first      = link_v0[StageCount];
  assign out_result_second     = link_v1[StageCount];

endmodule
